FILE: src/spmf_pkg.sv
// Shared types and codes for the strict priority multi-queue unit.
package spmf_pkg;

    // Field widths fixed by the item formats
    localparam int WORD_W  = 32;
    localparam int LVL_W   = 3;
    localparam int STAT_W  = 3;
    localparam int NLVL_W  = 4;

    // Operation codes
    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_ENQ      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_DEQ      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BADLEVEL = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

    // Input beat
    typedef struct packed {
        logic                     func;
        logic signed [WORD_W-1:0] data_in;
        logic [LVL_W-1:0]         level_in;
    } in_item_t;

    // Result beat
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic signed [WORD_W-1:0] data_out;
        logic [LVL_W-1:0]         level_out;
    } out_item_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic              exec;
        logic              deq;
        logic [LVL_W-1:0]  level;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

    // Link passed from one cell to its higher-numbered neighbor
    typedef struct packed {
        logic              taken;
        logic              full;
        logic              hit;
        logic [WORD_W-1:0] word;
        logic [LVL_W-1:0]  level;
    } link_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

endpackage

FILE: src/strict_priority_multi_fifo_unit.sv
// Top level of the strict priority multi-queue unit: sequencer and row of level cells.
//
// Usage: drive cmd and raise start while busy is low; the beat is taken at
// that clock edge. func selects enqueue (data_in goes to the queue of
// level_in) or dequeue (the head of the lowest-numbered non-empty level in
// use is popped). Each beat yields exactly one result beat on rsp, marked by
// done for a single cycle; the receiver cannot stall it, so it must take it.
// At the accepting edge the command is registered; the unit then passes
// through S_EXEC, in which the chosen level cell updates its pointers
// and its queue memory port reads or writes, and S_RESP, in which done is
// high and the result taken from the end of the cell chain is presented.
// busy is high in both states, so no new beat is taken before the result.
// num_levels is written via cfg_we/cfg_data by the user only while the unit is idle;
// the block does not enforce it. Enqueue refuses and dequeue skips levels >= it.
// Reset clears all queues to empty, sets num_levels to 8 and the unit idle.
// Queue memories hold no reset value; only filled slots are ever read.
module strict_priority_multi_fifo_unit #(
    parameter int LEVELS = 8,
    parameter int DEPTH  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  spmf_pkg::in_item_t           cmd,
    output logic                         done,
    output spmf_pkg::out_item_t          rsp,
    input  logic                         cfg_we,
    input  logic [spmf_pkg::NLVL_W-1:0]  cfg_data
);
    import spmf_pkg::*;

    localparam int EW = NLVL_W + 1;

    state_t state_reg, state_next;
    in_item_t cmd_reg;
    logic [NLVL_W-1:0] num_levels_reg;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [EW-1:0] eff_count;
    logic bad_level;
    logic exec;
    cell_cmd_t cell_cmd;
    link_t links [LEVELS + 1];
    logic [LEVELS-1:0] hit_vec;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        busy = 1'b1;
        exec = 1'b0;
        done = 1'b0;
        case (state_reg)
            S_IDLE:  busy = 1'b0;
            S_EXEC:  exec = 1'b1;
            S_RESP:  done = 1'b1;
            default: busy = 1'b0;
        endcase
    end

    // Hold state and the configured level count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            num_levels_reg <= NLVL_W'(8);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                num_levels_reg <= cfg_data;
            end
        end
    end

    // Capture the command beat and the decided status
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            cmd_reg <= cmd;
        end
        status_reg <= status_next;
    end

    // Broadcast the command to the cells
    always_comb
    begin
        cell_cmd.exec  = exec;
        cell_cmd.deq   = (cmd_reg.func == FUNC_DEQ);
        cell_cmd.level = cmd_reg.level_in;
        cell_cmd.word  = cmd_reg.data_in;
    end

    // Decide status from the chain end during execution
    always_comb
    begin
        eff_count = (EW'(num_levels_reg) > EW'(LEVELS)) ? EW'(LEVELS)
                                                        : EW'(num_levels_reg);
        bad_level = (EW'(cmd_reg.level_in) >= eff_count);
        status_next = status_reg;
        if (exec)
        begin
            if (cmd_reg.func == FUNC_DEQ)
            begin
                status_next = links[LEVELS].taken ? STAT_DEQ : STAT_EMPTY;
            end
            else if (bad_level)
            begin
                status_next = STAT_BADLEVEL;
            end
            else if (links[LEVELS].full)
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                status_next = STAT_ENQ;
            end
        end
    end

    // Row of level cells, level 0 at the head of the chain
    assign links[0] = '0;

    for (genvar i = 0; i < LEVELS; i++)
    begin : g_cell
        spmf_cell #(
            .IDX   (i),
            .DEPTH (DEPTH)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cell_cmd),
            .num_levels (num_levels_reg),
            .link_in    (links[i]),
            .link_out   (links[i + 1]),
            .hit        (hit_vec[i])
        );
    end

    // Drive the result beat
    always_comb
    begin
        rsp.status    = status_reg;
        rsp.data_out  = (status_reg == STAT_DEQ) ? links[LEVELS].word : '0;
        rsp.level_out = (status_reg == STAT_DEQ) ? links[LEVELS].level : '0;
    end

    // At most one cell pops per command
    a_one_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one level popped");

    // A result follows an execution cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(exec))
        else $error("result without execution");

    // An accepted beat makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && exec))
        else $error("accepted beat did not start execution");

    // Only a successful dequeue carries a word
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != STAT_DEQ) |-> (rsp.data_out == '0 && rsp.level_out == '0))
        else $error("data on a non-dequeue result");

    // A successful dequeue came from exactly one cell
    a_deq_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status == STAT_DEQ) |-> $onehot(hit_vec))
        else $error("dequeue result without a popped level");

endmodule

FILE: src/spmf_cell.sv
// One priority level: its queue memory, pointers, fill count and chain link.
module spmf_cell #(
    parameter int IDX   = 0,
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  spmf_pkg::cell_cmd_t          cmd,
    input  logic [spmf_pkg::NLVL_W-1:0]  num_levels,
    input  spmf_pkg::link_t              link_in,
    output spmf_pkg::link_t              link_out,
    output logic                         hit
);
    import spmf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [LVL_W-1:0] MY_LEVEL = LVL_W'(IDX);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          hit_reg, hit_next;

    logic active, match, nonempty, full, wr, rd;

    // Decode this level's role in the current command
    always_comb
    begin
        active   = (IDX < int'(num_levels));
        match    = (IDX < (1 << LVL_W)) && (cmd.level == MY_LEVEL);
        nonempty = (cnt_reg != '0);
        full     = (cnt_reg == CW'(DEPTH));
        wr       = cmd.exec && !cmd.deq && match && active && !full;
        rd       = cmd.exec && cmd.deq && !link_in.taken && active && nonempty;
    end

    // Advance pointers and count
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        hit_next  = cmd.exec ? rd : hit_reg;
        if (wr)
        begin
            tail_next = (tail_reg == PW'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            cnt_next  = cnt_reg + 1'b1;
        end
        if (rd)
        begin
            head_next = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            cnt_next  = cnt_reg - 1'b1;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
            hit_reg  <= hit_next;
        end
    end

    // Queue storage: write at tail, registered read at head
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[tail_reg] <= cmd.word;
        end
        if (rd)
        begin
            rdata_reg <= mem[head_reg];
        end
    end

    // Hand priority, full flag and popped word to the next cell
    always_comb
    begin
        link_out.taken = link_in.taken || (active && nonempty);
        link_out.full  = link_in.full || (match && active && full);
        link_out.hit   = link_in.hit || hit_reg;
        link_out.word  = hit_reg ? rdata_reg : link_in.word;
        link_out.level = hit_reg ? MY_LEVEL : link_in.level;
    end

    assign hit = hit_reg;

endmodule

FILE: verif/strict_priority_multi_fifo_unit_tb.sv
// Self-checking testbench for the strict priority multi-queue unit.
`timescale 1ns / 1ps

module strict_priority_multi_fifo_unit_tb;
    import spmf_pkg::*;

    localparam int LEVELS      = 8;
    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYC  = 4;
    localparam int MAX_PRINTS  = 40;

    logic                clk    = 1'b0;
    logic                rst_n  = 1'b0;
    logic                start  = 1'b0;
    logic                busy;
    in_item_t            cmd    = '0;
    logic                done;
    out_item_t           rsp;
    logic                cfg_we   = 1'b0;
    logic [NLVL_W-1:0]   cfg_data = '0;

    // Shadow queues and level count
    logic [WORD_W-1:0]   shadow_word [LEVELS][DEPTH];
    int                  shadow_head [LEVELS];
    int                  shadow_tail [LEVELS];
    int                  shadow_fill [LEVELS];
    logic [NLVL_W-1:0]   level_count;

    out_item_t           pending_rsp [$];
    out_item_t           want_rsp;
    int                  idle_pct;
    int                  error_count;
    int                  cycle_count;
    int                  beats_sent;
    int                  status_seen [5];

    strict_priority_multi_fifo_unit #(
        .LEVELS (LEVELS),
        .DEPTH  (DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_rsp.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $time, what);
        error_count++;
    endtask

    // Apply one operation to the shadow queues and return the expected result beat
    function automatic out_item_t queue_op_result(input in_item_t it);
        out_item_t r;
        int        active;
        int        lv;
        int        i;
        bit        found;
        r      = '0;
        active = (level_count > LEVELS) ? LEVELS : int'(level_count);
        if (it.func == FUNC_ENQ)
        begin
            lv = int'(it.level_in);
            if (lv >= active)
                r.status = STAT_BADLEVEL;
            else if (shadow_fill[lv] >= DEPTH)
                r.status = STAT_FULL;
            else
            begin
                shadow_word[lv][shadow_tail[lv]] = it.data_in;
                shadow_tail[lv] = (shadow_tail[lv] + 1) % DEPTH;
                shadow_fill[lv]++;
                r.status = STAT_ENQ;
            end
        end
        else
        begin
            // Serve the lowest-numbered non-empty level in use
            r.status = STAT_EMPTY;
            found    = 1'b0;
            for (i = 0; i < active && !found; i++)
            begin
                if (shadow_fill[i] != 0)
                begin
                    r.data_out  = shadow_word[i][shadow_head[i]];
                    r.level_out = i[LVL_W-1:0];
                    r.status    = STAT_DEQ;
                    shadow_head[i] = (shadow_head[i] + 1) % DEPTH;
                    shadow_fill[i]--;
                    found = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_rsp.size() == 0)
                report_mismatch($sformatf("unexpected result beat status=%0d", rsp.status));
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (want_rsp.status <= STAT_FULL)
                    status_seen[want_rsp.status]++;
                if (rsp.status !== want_rsp.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              rsp.status, want_rsp.status));
                if (rsp.data_out !== want_rsp.data_out)
                    report_mismatch($sformatf("data_out %h, expected %h",
                                              rsp.data_out, want_rsp.data_out));
                if (rsp.level_out !== want_rsp.level_out)
                    report_mismatch($sformatf("level_out %0d, expected %0d",
                                              rsp.level_out, want_rsp.level_out));
            end
        end
    end

    // Present one beat, wait for the accepting edge, then idle at random
    task automatic send_beat(input logic func, input logic [WORD_W-1:0] word,
                             input logic [LVL_W-1:0] lvl);
        in_item_t it;
        int       gap;
        it.func     = func;
        it.data_in  = word;
        it.level_in = lvl;
        cmd   <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_rsp.push_back(queue_op_result(it));
        beats_sent++;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct && gap < 20)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold the sender off until every result is back and the unit is idle
    task automatic wait_quiet();
        start <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_level_count(input logic [NLVL_W-1:0] value);
        wait_quiet();
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        level_count = value;
        cfg_we <= 1'b0;
    endtask

    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return {WORD_W{1'b1}};
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    // Bursts that lean toward enqueue or dequeue so queues hit full and empty
    task automatic run_random_traffic(input int n_items);
        int               sent;
        int               burst_len;
        int               enq_pct;
        int               active;
        int               hot;
        int               i;
        int               pick;
        logic [LVL_W-1:0] lvl;
        sent = 0;
        while (sent < n_items)
        begin
            burst_len = $urandom_range(8, 40);
            case ($urandom_range(0, 2))
                0:       enq_pct = 20;
                1:       enq_pct = 50;
                default: enq_pct = 85;
            endcase
            active = (level_count > LEVELS) ? LEVELS : int'(level_count);
            hot    = (active == 0) ? 0 : $urandom_range(0, active - 1);
            for (i = 0; i < burst_len && sent < n_items; i++)
            begin
                if ($urandom_range(0, 99) < enq_pct)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0 || active == 0)
                        lvl = LVL_W'($urandom_range(0, LEVELS - 1));
                    else if (pick <= 5)
                        lvl = LVL_W'(hot);
                    else
                        lvl = LVL_W'($urandom_range(0, active - 1));
                    send_beat(FUNC_ENQ, pick_word(), lvl);
                end
                else
                    send_beat(FUNC_DEQ, $urandom, LVL_W'($urandom_range(0, LEVELS - 1)));
                sent++;
            end
            if ($urandom_range(0, 7) == 0)
                wait_quiet();
        end
    endtask

    // Empty, full, out-of-range, hidden levels, zero and saturated level count
    task automatic test_directed();
        int k;
        idle_pct = 0;
        send_beat(FUNC_DEQ, 32'h7fff_ffff, 3'd7);
        send_beat(FUNC_ENQ, 32'h8000_0000, 3'd0);
        send_beat(FUNC_ENQ, 32'h7fff_ffff, 3'd0);
        send_beat(FUNC_ENQ, 32'h0000_0000, 3'd0);
        send_beat(FUNC_ENQ, 32'hffff_ffff, 3'd0);
        for (k = 4; k < DEPTH; k++)
            send_beat(FUNC_ENQ, $urandom, 3'd0);
        send_beat(FUNC_ENQ, 32'h1234_5678, 3'd0);
        send_beat(FUNC_ENQ, $urandom, 3'd7);
        write_level_count(4'd2);
        send_beat(FUNC_ENQ, $urandom, 3'd7);
        send_beat(FUNC_ENQ, $urandom, 3'd1);
        send_beat(FUNC_DEQ, 32'h0, 3'd0);
        write_level_count(4'd0);
        send_beat(FUNC_ENQ, $urandom, 3'd0);
        send_beat(FUNC_DEQ, $urandom, 3'd5);
        write_level_count(4'd15);
        send_beat(FUNC_DEQ, $urandom, 3'd7);
    endtask

    task automatic test_full_rate();
        write_level_count(4'd8);
        idle_pct = 0;
        run_random_traffic(350);
    endtask

    task automatic test_sender_idle();
        write_level_count(4'd3);
        idle_pct = 53;
        run_random_traffic(350);
    endtask

    task automatic test_mixed_idle();
        write_level_count(4'd6);
        idle_pct = 35;
        run_random_traffic(300);
    endtask

    task automatic test_level_count_sweep();
        idle_pct = 35;
        write_level_count(4'd1);
        run_random_traffic(100);
        write_level_count(4'd4);
        run_random_traffic(100);
        idle_pct = 0;
        write_level_count(4'd15);
        run_random_traffic(80);
        write_level_count(4'd0);
        run_random_traffic(20);
        idle_pct = 53;
        write_level_count(4'd8);
        run_random_traffic(50);
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        beats_sent  = 0;
        idle_pct    = 0;
        level_count = 4'd8;
        foreach (shadow_fill[i])
        begin
            shadow_head[i] = 0;
            shadow_tail[i] = 0;
            shadow_fill[i] = 0;
        end
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Hold reset low, then release it
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_rate();
        test_sender_idle();
        test_mixed_idle();
        test_level_count_sweep();

        wait_quiet();
        repeat (SETTLE_CYC) @(posedge clk);

        $display("Sent %0d beats over level counts 0..15 with idle rates 0, 35 and 53 pct",
                 beats_sent);
        $display("Results: %0d enqueued, %0d dequeued, %0d bad level, %0d empty, %0d full",
                 status_seen[STAT_ENQ], status_seen[STAT_DEQ], status_seen[STAT_BADLEVEL],
                 status_seen[STAT_EMPTY], status_seen[STAT_FULL]);
        if (error_count == 0 && pending_rsp.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
